FILE: rtl/normal_cdf_polynomial_approx_macros.svh
// Assertion helpers for the normal CDF block.
`ifndef NORMAL_CDF_POLYNOMIAL_APPROX_MACROS_SVH
`define NORMAL_CDF_POLYNOMIAL_APPROX_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define NCDF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NCDF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NCDF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define NCDF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/ncdf_pkg.sv
package ncdf_pkg;

   localparam int X_W   = 15;  // Q3.11 argument
   localparam int A_W   = 15;  // |x|, 0 .. 16384
   localparam int CDF_W = 16;  // Q0.16 result
   localparam int T_W   = 31;  // t in Q30, up to 1.0
   localparam int PW    = 35;  // signed polynomial accumulator
   localparam int PM_W  = 34;  // polynomial magnitude
   localparam int DEN_W = 29;  // density in Q30, below 0.5

   localparam int TAYLOR_TERMS = 10;
   localparam int SQUARINGS    = 6;
   localparam int DIV_BITS     = T_W;

   localparam int RECIP_LAT = 2 + DIV_BITS;
   localparam int GAUSS_LAT = 1 + 4 * TAYLOR_TERMS + 2 * SQUARINGS + 2;
   localparam int POLY_LAT  = 3 * 5;
   localparam int ALIGN_LAT = GAUSS_LAT - RECIP_LAT - POLY_LAT;

   localparam longint unsigned ONE30_L = 64'd1073741824;

   localparam logic [27:0] K_P =
      28'((64'd2316419 * ONE30_L + 64'd5000000) / 64'd10000000);
   localparam logic [DEN_W-1:0] K_INV_SQRT_2PI =
      DEN_W'((64'd3989422804 * ONE30_L + 64'd5000000000) / 64'd10000000000);

   localparam longint K_B1_L =
      longint'((64'd319381530 * ONE30_L + 64'd500000000) / 64'd1000000000);
   localparam longint K_B2_L =
      -longint'((64'd356563782 * ONE30_L + 64'd500000000) / 64'd1000000000);
   localparam longint K_B3_L =
      longint'((64'd1781477937 * ONE30_L + 64'd500000000) / 64'd1000000000);
   localparam longint K_B4_L =
      -longint'((64'd1821255978 * ONE30_L + 64'd500000000) / 64'd1000000000);
   localparam longint K_B5_L =
      longint'((64'd1330274429 * ONE30_L + 64'd500000000) / 64'd1000000000);

   localparam logic signed [PW-1:0] K_B5 = PW'(K_B5_L);

   // Constant added after each Horner multiply; the last step adds nothing.
   localparam logic signed [PW-1:0] POLY_ADD [5] = '{
      PW'(K_B4_L), PW'(K_B3_L), PW'(K_B2_L), PW'(K_B1_L), PW'(0)
   };

   // ceil(2^34 / k): exact quotient for dividends below 2^30.
   localparam logic [34:0] TAYLOR_RECIP [1:10] = '{
      35'((64'd17179869184 + 64'd0) / 64'd1),
      35'((64'd17179869184 + 64'd1) / 64'd2),
      35'((64'd17179869184 + 64'd2) / 64'd3),
      35'((64'd17179869184 + 64'd3) / 64'd4),
      35'((64'd17179869184 + 64'd4) / 64'd5),
      35'((64'd17179869184 + 64'd5) / 64'd6),
      35'((64'd17179869184 + 64'd6) / 64'd7),
      35'((64'd17179869184 + 64'd7) / 64'd8),
      35'((64'd17179869184 + 64'd8) / 64'd9),
      35'((64'd17179869184 + 64'd9) / 64'd10)
   };

endpackage

FILE: rtl/ncdf_req_if.sv
interface ncdf_req_if;
   import ncdf_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [X_W-1:0]   x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

FILE: rtl/ncdf_rsp_if.sv
interface ncdf_rsp_if;
   import ncdf_pkg::*;

   logic                valid;
   logic                ready;
   logic [CDF_W-1:0]    cdf_value;

   modport source (output valid, output cdf_value, input ready);
   modport sink   (input valid, input cdf_value, output ready);
endinterface

FILE: rtl/normal_cdf_polynomial_approx.sv
// Channel  Dir  Payload                          Handshake
// req_ch   in   x_value   Q3.11 signed, 15 bit   valid/ready
// rsp_ch   out  cdf_value Q0.16 unsigned, 16 bit valid/ready
//
// One transaction a cycle in, one out, while the output buffer is not full;
// the density path (series, squarings) is the longest from acceptance to result.
// Reset (synchronous) clears every valid bit and the output buffer count.
// A two-entry output buffer parts the sides: the pipeline halts as a whole
// only when both entries are held, so a new transaction is taken while one
// result waits.
`include "normal_cdf_polynomial_approx_macros.svh"

module normal_cdf_polynomial_approx (
   input  logic       clock,
   input  logic       reset,
   ncdf_req_if.sink   req_ch,
   ncdf_rsp_if.source rsp_ch
);
   import ncdf_pkg::*;

   localparam logic [33:0] ONE34 = 34'h0_4000_0000;

   // Pipeline advance: hold everything while both output entries are taken.
   logic en;

   // Input stage.
   logic           s0_v_ff;
   logic           s0_neg_ff;
   logic [A_W-1:0] s0_a_ff;
   logic [A_W-1:0] a_in;

   logic [T_W-1:0]   t_w;
   logic             g_v;
   logic [DEN_W-1:0] dens_w;

   // Horner stages: magnitude, multiply, round-and-add per coefficient.
   logic               sg_ff [5];
   logic [PM_W-1:0]    mg_ff [5];
   logic [T_W-1:0]     ta_ff [5];
   logic [64:0]        pm_ff [5];
   logic               sm_ff [5];
   logic [T_W-1:0]     tm_ff [5];
   logic signed [PW-1:0] pv_ff [5];
   logic [T_W-1:0]     tr_ff [4];

   logic [PM_W-1:0] poly_w;
   logic [PM_W-1:0] al_ff  [ALIGN_LAT];
   logic            ng_ff  [GAUSS_LAT];

   // Tail and output stages.
   logic        f1_v_ff, f2_v_ff, f3_v_ff;
   logic        f1_neg_ff, f2_neg_ff;
   logic [62:0] tp_ff;
   logic [63:0] tail_sum;
   logic [33:0] tail_ff;
   logic [33:0] v30_ff;
   logic [34:0] v16_sum;
   logic [CDF_W-1:0] v16;

   // Output buffer.
   logic [1:0]       cnt_ff, cnt_in;
   logic [CDF_W-1:0] head_ff, head_in;
   logic [CDF_W-1:0] spare_ff, spare_in;
   logic             push, pop;

   assign en           = (cnt_ff != 2'd2);
   assign req_ch.ready = en;

   // Fold the sign away; the most negative code gives |x| = 8.0.
   assign a_in = req_ch.x_value[X_W-1]
                 ? A_W'(16'h8000 - {1'b0, req_ch.x_value})
                 : A_W'(req_ch.x_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_a_ff   <= a_in;
         s0_neg_ff <= req_ch.x_value[X_W-1];
      end
   end

   ncdf_recip u_recip (
      .clock (clock),
      .en    (en),
      .a     (s0_a_ff),
      .t     (t_w)
   );

   ncdf_gauss u_gauss (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_v_ff),
      .a         (s0_a_ff),
      .out_valid (g_v),
      .dens      (dens_w)
   );

   // Horner evaluation of t*(b1 + t*(b2 + t*(b3 + t*(b4 + t*b5))))
   for (genvar n = 0; n < 5; n++) begin : g_poly
      logic signed [PW-1:0] pv_prev;
      logic [T_W-1:0]       t_prev;
      logic [65:0]          rsum;
      logic signed [35:0]   ps;
      logic signed [35:0]   val;

      if (n == 0) begin : g_first
         assign pv_prev = K_B5;
         assign t_prev  = t_w;
      end else begin : g_next
         assign pv_prev = pv_ff[n-1];
         assign t_prev  = tr_ff[n-1];
      end

      always_comb begin
         rsum = 66'(pm_ff[n]) + 66'(ONE34 >> 1);
         ps   = $signed({1'b0, rsum[64:30]});
         val  = (sm_ff[n] ? -ps : ps) + 36'(POLY_ADD[n]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sg_ff[n] <= pv_prev[PW-1];
            mg_ff[n] <= pv_prev[PW-1] ? PM_W'(-pv_prev) : PM_W'(pv_prev);
            ta_ff[n] <= t_prev;
            pm_ff[n] <= 65'(mg_ff[n]) * 65'(ta_ff[n]);
            sm_ff[n] <= sg_ff[n];
            tm_ff[n] <= ta_ff[n];
         end
      end

      if (n < 4) begin : g_mid
         always_ff @(posedge clock) begin
            if (en) begin
               pv_ff[n] <= PW'(val);
               tr_ff[n] <= tm_ff[n];
            end
         end
      end else begin : g_last
         // Clamp a negative polynomial result to zero.
         always_ff @(posedge clock) begin
            if (en) begin
               pv_ff[n] <= val[35] ? '0 : PW'(val);
            end
         end
      end
   end

   assign poly_w = PM_W'(pv_ff[4]);

   // Line the polynomial and the sign up with the density.
   always_ff @(posedge clock) begin
      if (en) begin
         al_ff[0] <= poly_w;
         for (int k = 1; k < ALIGN_LAT; k++) begin
            al_ff[k] <= al_ff[k-1];
         end
         ng_ff[0] <= s0_neg_ff;
         for (int k = 1; k < GAUSS_LAT; k++) begin
            ng_ff[k] <= ng_ff[k-1];
         end
      end
   end

   assign tail_sum = {1'b0, tp_ff} + 64'(ONE34 >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= g_v;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tp_ff     <= 63'(dens_w) * 63'(al_ff[ALIGN_LAT-1]);
         f1_neg_ff <= ng_ff[GAUSS_LAT-1];
         tail_ff   <= tail_sum[63:30];
         f2_neg_ff <= f1_neg_ff;
         // Negative x takes the tail; otherwise one minus it, floored at zero.
         if (f2_neg_ff) begin
            v30_ff <= tail_ff;
         end else begin
            v30_ff <= (tail_ff >= ONE34) ? '0 : ONE34 - tail_ff;
         end
      end
   end

   // Round Q30 to Q16 and saturate at all ones.
   assign v16_sum = 35'(v30_ff) + 35'd8192;
   assign v16     = (v16_sum[34:14] > 21'd65535) ? '1 : v16_sum[29:14];

   assign push = en & f3_v_ff;
   assign pop  = rsp_ch.valid & rsp_ch.ready;

   always_comb begin
      cnt_in   = cnt_ff;
      head_in  = head_ff;
      spare_in = spare_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = v16;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = v16;
            end else if (push) begin
               spare_in = v16;
               cnt_in   = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = spare_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign rsp_ch.valid     = (cnt_ff != 2'd0);
   assign rsp_ch.cdf_value = head_ff;

   // A full buffer that is not drained stays full and keeps its head.
   `NCDF_ASSERT_NXT(a_full_hold, clock, reset, (cnt_ff == 2'd2) && !pop, (cnt_ff == 2'd2) && $stable(head_ff), "full output buffer lost or changed a result")
   // A halted pipeline keeps its last valid bit.
   `NCDF_ASSERT_NXT(a_stall_hold, clock, reset, !en, $stable(f3_v_ff) && $stable(v30_ff), "stalled pipeline moved")
   // For negative x the CDF stays at or below one half.
   `NCDF_ASSERT_IMP(a_neg_half, clock, reset, f3_v_ff && $past(f2_neg_ff) && $past(en), v30_ff <= 34'h0_2000_0000, "negative argument gave a CDF above one half")

endmodule

FILE: rtl/ncdf_recip.sv
// t = round(2^60 / (1 + p*a)) by a restoring divider, one quotient bit a stage.
module ncdf_recip (
   input  logic                      clock,
   input  logic                      en,
   input  logic [ncdf_pkg::A_W-1:0]  a,
   output logic [ncdf_pkg::T_W-1:0]  t
);
   import ncdf_pkg::*;

   logic [42:0] pa_ff;
   logic [31:0] den_ff;
   logic [43:0] den_sum;

   logic [31:0]      rem_ff [DIV_BITS-1];
   logic [31:0]      dd_ff  [DIV_BITS-1];
   logic [T_W-1:0]   q_ff   [DIV_BITS];

   assign den_sum = 44'(pa_ff) + 44'd1024;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff  <= 43'(a) * 43'(K_P);
         den_ff <= 32'(33'(ONE30_L) + den_sum[43:11]);
      end
   end

   // Numerator is 2^60 + den/2: top part starts the remainder at 2^29,
   // low bits are den shifted right by one.
   for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
      localparam int B = DIV_BITS - 1 - i;
      logic [31:0]    rem_prev;
      logic [31:0]    dd_prev;
      logic [T_W-1:0] q_prev;
      logic [T_W-1:0] q_in;
      logic [32:0]    trial;
      logic [32:0]    diff;
      logic           ge;

      if (i == 0) begin : g_first
         assign rem_prev = 32'h2000_0000;
         assign dd_prev  = den_ff;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign dd_prev  = dd_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      always_comb begin
         trial = {rem_prev, dd_prev[B+1]};
         diff  = trial - {1'b0, dd_prev};
         ge    = trial >= {1'b0, dd_prev};
         q_in  = q_prev;
         q_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i] <= q_in;
         end
      end

      if (i < DIV_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? diff[31:0] : trial[31:0];
               dd_ff[i]  <= dd_prev;
            end
         end
      end
   end

   assign t = q_ff[DIV_BITS-1];

endmodule

FILE: rtl/ncdf_gauss.sv
// Density exp(-x^2/2)/sqrt(2*pi) in Q30: Taylor series of exp(-x^2/128),
// six squarings, then the scale.
module ncdf_gauss (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ncdf_pkg::A_W-1:0]    a,
   output logic                        out_valid,
   output logic [ncdf_pkg::DEN_W-1:0]  dens
);
   import ncdf_pkg::*;

   localparam int TT = TAYLOR_TERMS;
   localparam int SQ = SQUARINGS;
   localparam logic [30:0] ONE31 = 31'h4000_0000;

   logic [GAUSS_LAT-1:0] v_ff;
   logic [29:0]          r0_ff;

   logic [59:0] tp_ff  [TT];
   logic [29:0] tra_ff [TT];
   logic [29:0] trb_ff [TT];
   logic [29:0] trc_ff [TT];
   logic [29:0] trd_ff [TT-1];
   logic [29:0] tz_ff  [TT];
   logic [64:0] tzm_ff [TT];
   logic [30:0] ts_ff  [TT];

   logic [61:0] sqp_ff [SQ];
   logic [30:0] sqs_ff [SQ];

   logic [59:0]      dp_ff;
   logic [DEN_W-1:0] dens_ff;
   logic [60:0]      dsum;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[GAUSS_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff <= 30'(30'(a) * 30'(a)) << 1;  // x*x/128 in Q30
      end
   end

   for (genvar j = 0; j < TT; j++) begin : g_tay
      localparam int K = TT - j;
      localparam logic [60:0] RND = 61'(K) << 29;
      logic [30:0] s_prev;
      logic [29:0] r_prev;
      logic [60:0] zsum;
      logic [30:0] q;

      if (j == 0) begin : g_first
         assign s_prev = ONE31;
         assign r_prev = r0_ff;
      end else begin : g_next
         assign s_prev = ts_ff[j-1];
         assign r_prev = trd_ff[j-1];
      end

      assign zsum = {1'b0, tp_ff[j]} + RND;
      assign q    = tzm_ff[j][64:34];

      always_ff @(posedge clock) begin
         if (en) begin
            tp_ff[j]  <= 60'(r_prev) * 60'(s_prev);
            tra_ff[j] <= r_prev;
            tz_ff[j]  <= zsum[59:30];
            trb_ff[j] <= tra_ff[j];
            tzm_ff[j] <= 65'(tz_ff[j]) * 65'(TAYLOR_RECIP[K]);
            trc_ff[j] <= trb_ff[j];
            ts_ff[j]  <= (q >= ONE31) ? 31'd0 : ONE31 - q;
         end
      end

      if (j < TT - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               trd_ff[j] <= trc_ff[j];
            end
         end
      end
   end

   for (genvar i = 0; i < SQ; i++) begin : g_sq
      logic [30:0] s_prev;
      logic [62:0] ssum;

      if (i == 0) begin : g_first
         assign s_prev = ts_ff[TT-1];
      end else begin : g_next
         assign s_prev = sqs_ff[i-1];
      end

      assign ssum = {1'b0, sqp_ff[i]} + 63'(ONE31 >> 1);

      always_ff @(posedge clock) begin
         if (en) begin
            sqp_ff[i] <= 62'(s_prev) * 62'(s_prev);
            sqs_ff[i] <= ssum[60:30];
         end
      end
   end

   assign dsum = {1'b0, dp_ff} + 61'(ONE31 >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff   <= 60'(sqs_ff[SQ-1]) * 60'(K_INV_SQRT_2PI);
         dens_ff <= dsum[58:30];
      end
   end

   assign out_valid = v_ff[GAUSS_LAT-1];
   assign dens      = dens_ff;

endmodule
